>>> hw/rtl/egi_pkg.sv
// Shared types and constants of the envelope gain interpolator.
// Holds command and register codes, configuration and queue entry structs.
// No dependencies.
`timescale 1ns / 1ps

package egi_pkg;

    localparam int INDEX_W    = 10;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 17;
    localparam int COUNT_W    = 11;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_COUNT = 2'd1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 16'd16384;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [COUNT_W-1:0] gain_count;
    } t_cfg;

    // fixed-width part of a queued item; the sample travels beside it
    typedef struct packed {
        logic               is_smp;
        logic               first;
        logic [INDEX_W-1:0] index;
        logic [GAIN_W-1:0]  gain;
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> hw/rtl/egi_if.sv
// Channel interfaces of the envelope gain interpolator: input items,
// result items and configuration writes. Depends on egi_pkg.
`timescale 1ns / 1ps

interface egi_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [egi_pkg::INDEX_W-1:0]    gain_index;
    logic [egi_pkg::GAIN_W-1:0]     gain_value;
    logic signed [SAMPLE_BITS-1:0]  sample_in;
    logic                           first_sample;

    modport source (output valid, cmd, gain_index, gain_value, sample_in, first_sample,
                    input ready);
    modport sink (input valid, cmd, gain_index, gain_value, sample_in, first_sample,
                  output ready);
endinterface

interface egi_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface

interface egi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [egi_pkg::CFG_IDX_W-1:0]    index;
    logic [egi_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/egi_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module egi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/egi_queue.sv
// Short item queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module egi_queue #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/egi_front.sv
// Front part: accepts input items, drops out-of-range table writes and
// packs the rest for the queue. Depends on egi_pkg and egi_if.
`timescale 1ns / 1ps

module egi_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int QW          = $bits(egi_pkg::t_op) + SAMPLE_BITS
) (
    egi_in_if.sink                  i_in,
    input  egi_pkg::t_back_stat     i_stat,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [QW-1:0]           o_data
);

    logic         w_accept;
    logic         w_in_range;
    egi_pkg::t_op w_op;

    assign i_in.ready = !i_stat.clearing && !i_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = (17'(i_in.gain_index) < 17'(TABLE_DEPTH));

    always_comb begin
        w_op.is_smp = (i_in.cmd == egi_pkg::CMD_SAMPLE);
        w_op.first  = i_in.first_sample;
        w_op.index  = i_in.gain_index;
        w_op.gain   = i_in.gain_value;
    end

    // drop table writes that fall past the end of the table
    assign o_push = w_accept && (w_op.is_smp || w_in_range);
    assign o_data = {w_op, i_in.sample_in};

endmodule

>>> hw/rtl/egi_back.sv
// Back part: executes queued items, owns the gain table RAM, the phase
// accumulator and the result register. Depends on egi_pkg, egi_if, egi_ram.
`timescale 1ns / 1ps

module egi_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int QW          = $bits(egi_pkg::t_op) + SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  egi_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  logic [QW-1:0]       i_q_data,
    output logic                o_q_pop,
    output egi_pkg::t_back_stat o_stat,
    egi_out_if.source           o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = SAMPLE_BITS;
    localparam int PW = SW + 17;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic signed [PW-1:0] MAXV = {{18{1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PW-1:0] MINV = {{18{1'b1}}, {(SW-1){1'b0}}};

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MULD = 3'd2;
    localparam logic [2:0] ST_GAIN = 3'd3;
    localparam logic [2:0] ST_MULS = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [1:0] CLS_UNITY  = 2'd0;
    localparam logic [1:0] CLS_INTERP = 2'd1;
    localparam logic [1:0] CLS_LAST   = 2'd2;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [31:0]           r_phase, n_phase;
    logic [1:0]            r_cls, n_cls;
    logic [15:0]           r_frac, n_frac;
    logic signed [SW-1:0]  r_sample, n_sample;
    logic signed [33:0]    r_dprod, n_dprod;
    logic [15:0]           r_gain, n_gain;
    logic signed [PW-1:0]  r_prod, n_prod;
    logic                  r_out_valid, n_out_valid;
    logic signed [SW-1:0]  r_out_data, n_out_data;

    egi_pkg::t_op          w_q_op;
    logic signed [SW-1:0]  w_q_sample;
    logic [16:0]           w_q_index_ext;
    logic [16:0]           w_cnt_ext;
    logic [16:0]           w_cnt;
    logic [31:0]           w_phase_use;
    logic [16:0]           w_frame;
    logic [16:0]           w_frame1;
    logic [1:0]            w_cls;
    logic [32:0]           w_phase_sum;
    logic [31:0]           w_phase_next;
    logic                  w_pop_smp;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [15:0]           w_wdata;
    logic                  w_re;
    logic [15:0]           w_rd_a;
    logic [15:0]           w_rd_b;

    logic signed [16:0]    w_diff;
    logic signed [16:0]    w_frac_s;
    logic signed [33:0]    w_rnd;
    logic signed [33:0]    w_adj;
    logic signed [17:0]    w_gain_sum;
    logic signed [16:0]    w_gain_s;
    logic signed [PW-1:0]  w_rsum;
    logic signed [PW-1:0]  w_q;
    logic signed [SW-1:0]  w_sat;
    logic                  w_slot_free;

    egi_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_frame[AW-1:0]),
        .i_raddr_b (w_frame1[AW-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_q_op        = egi_pkg::t_op'(i_q_data[QW-1:SW]);
    assign w_q_sample    = i_q_data[SW-1:0];
    assign w_q_index_ext = 17'(w_q_op.index);

    // effective entry count, clipped to the table size
    assign w_cnt_ext = 17'(i_cfg.gain_count);
    assign w_cnt     = (w_cnt_ext > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH) : w_cnt_ext;

    assign w_phase_use = w_q_op.first ? 32'd0 : r_phase;
    assign w_frame     = {1'b0, w_phase_use[31:16]};
    assign w_frame1    = w_frame + 17'd1;

    always_comb begin
        if (w_frame1 < w_cnt) begin
            w_cls = CLS_INTERP;
        end else if ((w_cnt != 17'd0) && (w_frame == w_cnt - 17'd1)) begin
            w_cls = CLS_LAST;
        end else begin
            w_cls = CLS_UNITY;
        end
    end

    // saturate the phase at its maximum
    assign w_phase_sum  = {1'b0, w_phase_use} + 33'(i_cfg.phase_step);
    assign w_phase_next = w_phase_sum[32] ? '1 : w_phase_sum[31:0];

    // gain = g0 + round(frac * (g1 - g0) / 65536)
    assign w_diff     = signed'({1'b0, w_rd_b}) - signed'({1'b0, w_rd_a});
    assign w_frac_s   = signed'({1'b0, r_frac});
    assign w_rnd      = r_dprod + 34'sd32768;
    assign w_adj      = w_rnd >>> 16;
    assign w_gain_sum = signed'({2'b00, w_rd_a}) + w_adj[17:0];
    assign w_gain_s   = signed'({1'b0, r_gain});

    // round to nearest, ties upward, then clamp to the sample range
    assign w_rsum = r_prod + PW'(8192);
    assign w_q    = w_rsum >>> 14;
    always_comb begin
        if (w_q > MAXV) begin
            w_sat = MAXV[SW-1:0];
        end else if (w_q < MINV) begin
            w_sat = MINV[SW-1:0];
        end else begin
            w_sat = w_q[SW-1:0];
        end
    end

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_pop_smp   = o_q_pop && w_q_op.is_smp;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_phase     = r_phase;
        n_cls       = r_cls;
        n_frac      = r_frac;
        n_sample    = r_sample;
        n_dprod     = r_dprod;
        n_gain      = r_gain;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = w_q_index_ext[AW-1:0];
        w_wdata     = w_q_op.gain;
        w_re        = 1'b0;
        o_q_pop     = 1'b0;
        case (r_state)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (w_q_op.is_smp) begin
                        w_re     = 1'b1;
                        n_cls    = w_cls;
                        n_frac   = w_phase_use[15:0];
                        n_sample = w_q_sample;
                        n_phase  = w_phase_next;
                        n_state  = ST_MULD;
                    end else begin
                        w_we = 1'b1;
                    end
                end
            end
            ST_MULD: begin
                n_dprod = w_frac_s * w_diff;
                n_state = ST_GAIN;
            end
            ST_GAIN: begin
                case (r_cls)
                    CLS_INTERP: n_gain = w_gain_sum[15:0];
                    CLS_LAST:   n_gain = w_rd_a;
                    default:    n_gain = egi_pkg::UNITY_GAIN;
                endcase
                n_state = ST_MULS;
            end
            ST_MULS: begin
                n_prod  = r_sample * w_gain_s;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_sat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls      <= n_cls;
        r_frac     <= n_frac;
        r_sample   <= n_sample;
        r_dprod    <= n_dprod;
        r_gain     <= n_gain;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    assign o_stat.clearing = (r_state == ST_CLR);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !o_out.ready)
            |=> (r_out_valid && $stable(r_out_data)))
        else $error("result overwritten while output stalled");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("table write and sample read in the same cycle");

    a_interp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAIN && r_cls == CLS_INTERP) |-> (w_cnt >= 17'd2))
        else $error("interpolation with fewer than two entries");

    a_phase_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_smp && !w_q_op.first) |=> (r_phase >= $past(r_phase)))
        else $error("phase moved backward without a restart");

endmodule

>>> hw/rtl/envelope_gain_interpolator_core.sv
// Top level of the envelope gain interpolator: configuration registers,
// front part, item queue and back part. Depends on egi_pkg, egi_if,
// egi_queue, egi_front, egi_back.
`timescale 1ns / 1ps

// Usage
//   i_in  : items. cmd = write stores gain_value at gain_index (indexes past
//           the table are dropped, no result); cmd = sample applies the
//           interpolated envelope gain to sample_in and yields one result.
//           first_sample restarts the envelope phase at that sample.
//   o_out : one sample_out per sample item, in item order.
//   i_cfg : index 0 = phase_step, 1 = gain_count; other indexes are ignored.
//           Always ready; write only while no item is in flight.
// Timing
//   After reset the back part clears all TABLE_DEPTH entries of the gain
//   table (1024 by default), one entry per cycle; i_in.ready stays low meanwhile.
//   Phase restarts at zero, phase_step = 65536, gain_count = 0.
//   The back part handles a sample in order: pop and table read, difference
//   multiply, gain, sample multiply, round and clamp. A table write is done
//   when its item is popped. The back part's single multiply-and-table
//   sequence takes a new sample only after the last one is through; a
//   4-entry queue absorbs bursts at the input.
//   When o_out stalls, the result register holds, the back part waits and
//   the queue fills; i_in.ready drops once the queue is full.
module envelope_gain_interpolator_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    egi_in_if.sink     i_in,
    egi_out_if.source  o_out,
    egi_cfg_if.sink    i_cfg
);

    localparam int QW = $bits(egi_pkg::t_op) + SAMPLE_BITS;

    logic [egi_pkg::STEP_W-1:0]  r_phase_step;
    logic [egi_pkg::STEP_W-1:0]  n_phase_step;
    logic [egi_pkg::COUNT_W-1:0] r_gain_count;
    logic [egi_pkg::COUNT_W-1:0] n_gain_count;
    egi_pkg::t_cfg               w_cfg;
    egi_pkg::t_back_stat         w_stat;
    logic                        w_push;
    logic [QW-1:0]               w_push_data;
    logic                        w_full;
    logic                        w_pop;
    logic                        w_q_valid;
    logic [QW-1:0]               w_q_data;

    // configuration writes land directly in the registers, so the port never stalls
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_phase_step = r_phase_step;
        n_gain_count = r_gain_count;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                egi_pkg::REG_PHASE_STEP: n_phase_step = i_cfg.data[egi_pkg::STEP_W-1:0];
                egi_pkg::REG_GAIN_COUNT: n_gain_count = i_cfg.data[egi_pkg::COUNT_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= egi_pkg::STEP_RESET;
            r_gain_count <= egi_pkg::COUNT_RESET;
        end else begin
            r_phase_step <= n_phase_step;
            r_gain_count <= n_gain_count;
        end
    end

    assign w_cfg.phase_step = r_phase_step;
    assign w_cfg.gain_count = r_gain_count;

    // front: accept and classify items
    egi_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_front (
        .i_in   (i_in),
        .i_stat (w_stat),
        .i_full (w_full),
        .o_push (w_push),
        .o_data (w_push_data)
    );

    // queue: decouple acceptance from execution
    egi_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back: table writes, phase, interpolation, gain and clamp
    egi_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_stat    (w_stat),
        .o_out     (o_out)
    );

endmodule
